/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* rtl/rtsp_ils_pkg.sv */
// ----------------------------------------------------------------------------
// rtsp_ils_pkg
// Types and constants shared by the line splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtsp_ils_pkg;

   // result kinds
   typedef enum logic [2:0] {
      KIND_FRAME     = 3'd0,
      KIND_DATA      = 3'd1,
      KIND_LINE_END  = 3'd2,
      KIND_REQ_END   = 3'd3,
      KIND_EMPTY_REQ = 3'd4,
      KIND_TOO_LONG  = 3'd5,
      KIND_CLOSED    = 3'd6
   } kind_type;

   // one result transaction
   typedef struct packed {
      kind_type     kind;
      logic [7:0]   data_byte;
      logic         last;
   } item_type;

   // results caused by one input byte (one or two)
   typedef struct packed {
      logic     two;
      item_type r0;
      item_type r1;
   } pair_type;

   localparam int          LEN_W     = 13;
   localparam int          FIFO_DEPTH = 4;
   localparam int          PTR_W     = 2;
   localparam int          CNT_W     = 3;

   localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
   localparam logic [7:0]  CHAR_LF     = 8'h0A;
   localparam logic [7:0]  CHAR_CR     = 8'h0D;

   localparam logic [LEN_W-1:0] LINE_LEN_RESET = 13'd4096;

endpackage

`default_nettype wire

/* rtl/rtsp_ils_parser.sv */
// ----------------------------------------------------------------------------
// rtsp_ils_parser
// Per-byte deframer state and the results each accepted byte causes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtsp_ils_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [7:0]                     in_byte,
   input  wire logic [rtsp_ils_pkg::LEN_W-1:0] limit,
   output      rtsp_ils_pkg::pair_type         res
);

   typedef enum logic [2:0] {
      PH_LINE_START = 3'd0,
      PH_LINE_BODY  = 3'd1,
      PH_CHAN       = 3'd2,
      PH_LEN_HI     = 3'd3,
      PH_LEN_LO     = 3'd4,
      PH_PAYLOAD    = 3'd5,
      PH_CLOSED     = 3'd6
   } phase_type;

   phase_type                        phase_ff,    phase_in;
   logic                             cr_held_ff,  cr_held_in;
   logic [7:0]                       len_hi_ff,   len_hi_in;
   logic [15:0]                      remain_ff,   remain_in;
   logic [rtsp_ils_pkg::LEN_W-1:0]   line_len_ff, line_len_in;
   logic                             have_ff,     have_in;

   // next state and results for the presented byte
   always_comb begin
      logic [rtsp_ils_pkg::LEN_W-1:0] len_cur;
      logic                           emitted;
      logic                           closed_now;
      rtsp_ils_pkg::item_type         data_res;

      phase_in    = phase_ff;
      cr_held_in  = cr_held_ff;
      len_hi_in   = len_hi_ff;
      remain_in   = remain_ff;
      line_len_in = line_len_ff;
      have_in     = have_ff;
      len_cur     = line_len_ff;
      emitted     = 1'b0;
      closed_now  = 1'b0;
      data_res    = '{kind: rtsp_ils_pkg::KIND_FRAME, data_byte: 8'd0, last: 1'b1};
      res.two     = 1'b0;
      res.r0      = '{kind: rtsp_ils_pkg::KIND_FRAME, data_byte: 8'd0, last: 1'b1};
      res.r1      = '{kind: rtsp_ils_pkg::KIND_FRAME, data_byte: 8'd0, last: 1'b1};

      case (phase_ff)
         PH_CHAN: begin
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_hi_in = in_byte;
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            remain_in = {len_hi_ff, in_byte};
            phase_in  = ({len_hi_ff, in_byte} == 16'd0) ? PH_LINE_START : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            remain_in = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               phase_in = PH_LINE_START;
            end
         end
         PH_LINE_START, PH_LINE_BODY: begin
            if (phase_ff == PH_LINE_START && in_byte == rtsp_ils_pkg::CHAR_DOLLAR) begin
               phase_in = PH_CHAN;
            end else if (in_byte == rtsp_ils_pkg::CHAR_LF) begin
               // line end; a held CR is dropped
               cr_held_in  = 1'b0;
               line_len_in = '0;
               if (line_len_ff != '0) begin
                  have_in       = 1'b1;
                  res.r0.kind   = rtsp_ils_pkg::KIND_LINE_END;
                  phase_in      = PH_LINE_START;
               end else if (have_ff) begin
                  have_in       = 1'b0;
                  res.r0.kind   = rtsp_ils_pkg::KIND_REQ_END;
                  phase_in      = PH_LINE_START;
               end else begin
                  res.r0.kind   = rtsp_ils_pkg::KIND_EMPTY_REQ;
                  phase_in      = PH_CLOSED;
               end
            end else begin
               phase_in   = PH_LINE_BODY;
               cr_held_in = 1'b0;
               // held CR not followed by LF becomes content
               if (cr_held_ff) begin
                  if (line_len_ff >= limit) begin
                     res.r0.kind = rtsp_ils_pkg::KIND_TOO_LONG;
                     phase_in    = PH_CLOSED;
                     closed_now  = 1'b1;
                  end else begin
                     res.r0   = '{kind: rtsp_ils_pkg::KIND_DATA,
                                  data_byte: rtsp_ils_pkg::CHAR_CR, last: 1'b1};
                     len_cur  = line_len_ff + 13'd1;
                     emitted  = 1'b1;
                  end
                  line_len_in = len_cur;
               end
               if (!closed_now) begin
                  if (in_byte == rtsp_ils_pkg::CHAR_CR) begin
                     // hold this CR until the next byte
                     cr_held_in = 1'b1;
                  end else begin
                     if (len_cur >= limit) begin
                        data_res.kind = rtsp_ils_pkg::KIND_TOO_LONG;
                        phase_in      = PH_CLOSED;
                     end else begin
                        data_res    = '{kind: rtsp_ils_pkg::KIND_DATA,
                                        data_byte: in_byte, last: 1'b1};
                        line_len_in = len_cur + 13'd1;
                     end
                     if (emitted) begin
                        res.r0.last = 1'b0;
                        res.r1      = data_res;
                        res.two     = 1'b1;
                     end else begin
                        res.r0      = data_res;
                     end
                  end
               end
            end
         end
         default: begin
            phase_in    = PH_CLOSED;
            res.r0.kind = rtsp_ils_pkg::KIND_CLOSED;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LINE_START;
         cr_held_ff  <= 1'b0;
         len_hi_ff   <= 8'd0;
         remain_ff   <= 16'd0;
         line_len_ff <= '0;
         have_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         cr_held_ff  <= cr_held_in;
         len_hi_ff   <= len_hi_in;
         remain_ff   <= remain_in;
         line_len_ff <= line_len_in;
         have_ff     <= have_in;
      end
   end

   // closed is sticky until reset
   `ASSERT_CLK(a_closed_sticky, clock, reset, phase_ff == PH_CLOSED |=> phase_ff == PH_CLOSED)
   // a byte gives two results only by releasing a held CR
   `ASSERT_CLK(a_two_needs_cr, clock, reset, res.two |-> cr_held_ff)
   // the first of two results is the released CR
   `ASSERT_CLK(a_two_first_cr, clock, reset,
      res.two |-> (res.r0.kind == rtsp_ils_pkg::KIND_DATA &&
                   res.r0.data_byte == rtsp_ils_pkg::CHAR_CR && !res.r0.last))

endmodule

`default_nettype wire

/* rtl/rtsp_ils_fifo.sv */
// ----------------------------------------------------------------------------
// rtsp_ils_fifo
// Result buffer: takes one or two results per cycle while not busy, sends one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtsp_ils_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire rtsp_ils_pkg::pair_type pair,
   output      logic                   busy,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rtsp_ils_pkg::item_type head
);

   rtsp_ils_pkg::item_type                entry_ff [rtsp_ils_pkg::FIFO_DEPTH];
   logic [rtsp_ils_pkg::PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [rtsp_ils_pkg::PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [rtsp_ils_pkg::CNT_W-1:0]        count_ff,  count_in;
   logic                                  pop;
   logic [rtsp_ils_pkg::PTR_W-1:0]        wr_next;

   assign rsp_valid = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for a pair is kept at all times the input is open
   assign busy      = (count_ff > 3'd2);
   assign wr_next   = wr_ptr_ff + 2'd1;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + (pair.two ? 2'd2 : 2'd1);
         count_in  = count_ff + (pair.two ? 3'd2 : 3'd1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         count_in  = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= pair.r0;
         if (pair.two) begin
            entry_ff[wr_next] <= pair.r1;
         end
      end
   end

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > 3'd4)
   `ASSERT_NEVER(a_push_while_busy, clock, reset, push && busy)
   `ASSERT_CLK(a_ptr_match, clock, reset, (wr_ptr_ff - rd_ptr_ff) == count_ff[1:0])

endmodule

`default_nettype wire

/* rtl/rtsp_interleave_line_splitter.sv */
// ----------------------------------------------------------------------------
// rtsp_interleave_line_splitter
// Splits an RTSP control byte stream into text lines and drops interleaved
// binary frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_in_byte carry one received byte per transaction.
//   rsp_valid/rsp_stall carry result transactions (rsp_kind, rsp_data_byte,
//   rsp_last); rsp_last marks the final result of one input byte.
//   csr_write_enable/csr_write_data load max_line_len; write only while idle.
// Timing:
//   A byte is parsed in the cycle it is accepted; its results are registered into
//   a four-entry result buffer. One byte per cycle is taken as long as the
//   receiver keeps up. A byte that releases a held CR gives two results, which
//   leave the buffer one after the other.
//   req_stall rises while three or more results wait in the buffer, so a
//   stalled receiver stops input after at most four results are queued.
// Reset:
//   Synchronous reset empties the buffer, returns to line start, clears the
//   request state and sets max_line_len to 4096. After an error every byte
//   reports closed until the next reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_interleave_line_splitter #(
   parameter int MAX_LINE = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_in_byte,
   // results
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_kind,
   output      logic [7:0]  rsp_data_byte,
   output      logic        rsp_last,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [12:0] csr_write_data
);

   // largest limit the 13-bit register can express under MAX_LINE
   localparam int LimCap = (MAX_LINE < 8191) ? MAX_LINE : 8191;
   localparam logic [rtsp_ils_pkg::LEN_W-1:0] LIM_CAP = LimCap[rtsp_ils_pkg::LEN_W-1:0];

   logic [rtsp_ils_pkg::LEN_W-1:0] max_line_len_ff;
   logic [rtsp_ils_pkg::LEN_W-1:0] limit;
   logic                           accept;
   logic                           busy;
   rtsp_ils_pkg::pair_type         pair;
   rtsp_ils_pkg::item_type         head;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_len_ff <= rtsp_ils_pkg::LINE_LEN_RESET;
      end else if (csr_write_enable) begin
         max_line_len_ff <= csr_write_data;
      end
   end

   // clamp the limit to 1..LIM_CAP (MAX_LINE, at most 8191)
   always_comb begin
      if (max_line_len_ff == '0) begin
         limit = 13'd1;
      end else if (max_line_len_ff > LIM_CAP) begin
         limit = LIM_CAP;
      end else begin
         limit = max_line_len_ff;
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   rtsp_ils_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .limit   (limit),
      .res     (pair)
   );

   rtsp_ils_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .pair      (pair),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind      = head.kind;
   assign rsp_data_byte = head.data_byte;
   assign rsp_last      = head.last;

endmodule

`default_nettype wire
